// ===== design/bee_pkg.sv =====
// ----------------------------------------------------------------------------
// bee_pkg
// Shared widths and constants for the byte entropy estimator.
// ----------------------------------------------------------------------------
package bee_pkg;

    localparam int MAX_BYTES = 4096;
    localparam int NBINS     = 256;
    localparam int BIN_W     = 8;
    localparam int CNT_W     = 13;
    localparam int FRAC_W    = 16;
    localparam int LG_W      = 20;    // 4 integer bits + 16 fraction bits
    localparam int TERM_W    = 34;    // n * log2(n) < 2^33
    localparam int MANT_W    = 31;    // Q1.30 mantissa
    localparam int ENT_W     = 20;
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;

    localparam logic [ENT_W-1:0] ENTROPY_MAX   = ENT_W'(524288);
    localparam logic [ENT_W-1:0] THRESH_RESET  = ENT_W'(458752);
    localparam logic [CNT_W-1:0] MAX_BYTES_CNT = CNT_W'(MAX_BYTES);

    // register index taken from the word address bit
    localparam logic REG_THRESH = 1'b0;

endpackage

// ===== design/bee_byte_if.sv =====
// ----------------------------------------------------------------------------
// bee_byte_if
// Input byte channel: valid/ready handshake with one byte and a last mark.
// ----------------------------------------------------------------------------
interface bee_byte_if;
    logic                         valid;
    logic                         ready;
    logic [bee_pkg::BIN_W-1:0]    data_byte;
    logic                         last_byte;

    modport source (output valid, data_byte, last_byte, input ready);
    modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

// ===== design/bee_result_if.sv =====
// ----------------------------------------------------------------------------
// bee_result_if
// Result channel: entropy value with threshold and empty flags.
// ----------------------------------------------------------------------------
interface bee_result_if;
    logic                         valid;
    logic                         ready;
    logic [bee_pkg::ENT_W-1:0]    entropy_value;
    logic                         above_threshold;
    logic                         empty_block;

    modport source (output valid, entropy_value, above_threshold, empty_block, input ready);
    modport sink   (input valid, entropy_value, above_threshold, empty_block, output ready);
endinterface

// ===== design/bee_hist.sv =====
// ----------------------------------------------------------------------------
// bee_hist
// 256-bin histogram memory with per-bin valid bits so that a clear empties every bin at once.
// ----------------------------------------------------------------------------
module bee_hist
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [bee_pkg::BIN_W-1:0]   rd_addr,
    output logic [bee_pkg::CNT_W-1:0]   rd_count,
    input  logic                        wr_en,
    input  logic [bee_pkg::BIN_W-1:0]   wr_addr,
    input  logic [bee_pkg::CNT_W-1:0]   wr_count,
    input  logic                        clear
);

    logic [bee_pkg::CNT_W-1:0] mem [bee_pkg::NBINS];
    logic [bee_pkg::NBINS-1:0] valid_reg;
    logic [bee_pkg::CNT_W-1:0] rdata_reg;
    logic                      rvalid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_count;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            rvalid_reg <= valid_reg[rd_addr] && !(wr_en && wr_addr == rd_addr) ?
                          1'b1 : valid_reg[rd_addr];
            if (clear)
            begin
                valid_reg <= '0;
            end
            else if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    // a bin never written in this block reads as zero
    assign rd_count = rvalid_reg ? rdata_reg : '0;

endmodule

// ===== design/bee_log2.sv =====
// ----------------------------------------------------------------------------
// bee_log2
// Fixed-point log2 of a 13-bit count: one mantissa squaring per cycle.
// ----------------------------------------------------------------------------
module bee_log2
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [bee_pkg::CNT_W-1:0]   x,
    output logic                        done,
    output logic [bee_pkg::LG_W-1:0]    result
);

    logic                         busy_reg;
    logic                         done_reg;
    logic [3:0]                   cnt_reg;
    logic [3:0]                   top_reg;
    logic [bee_pkg::MANT_W-1:0]   m_reg;
    logic [bee_pkg::FRAC_W-1:0]   frac_reg;

    logic [3:0]                   top;
    logic [2*bee_pkg::MANT_W-1:0] sq;
    logic [bee_pkg::MANT_W:0]     sq_top;
    logic [bee_pkg::MANT_W-1:0]   m_next;

    always_comb
    begin
        top = '0;
        for (int i = 0; i < bee_pkg::CNT_W; i++)
        begin
            if (x[i])
            begin
                top = 4'(i);
            end
        end
    end

    assign sq     = m_reg * m_reg;
    assign sq_top = sq[2*bee_pkg::MANT_W-1:bee_pkg::MANT_W-1];
    // m >= 2.0 after squaring: halve and emit a one
    assign m_next = sq_top[bee_pkg::MANT_W] ? sq_top[bee_pkg::MANT_W:1]
                                            : sq_top[bee_pkg::MANT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            top_reg  <= top;
            m_reg    <= bee_pkg::MANT_W'(x) << (5'd30 - {1'b0, top});
            frac_reg <= '0;
        end
        else if (busy_reg)
        begin
            m_reg    <= m_next;
            frac_reg <= {frac_reg[bee_pkg::FRAC_W-2:0], sq_top[bee_pkg::MANT_W]};
        end
    end

    assign done   = done_reg;
    assign result = {top_reg, frac_reg};

endmodule

// ===== design/bee_div.sv =====
// ----------------------------------------------------------------------------
// bee_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bee_div
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [bee_pkg::TERM_W-1:0]  dividend,
    input  logic [bee_pkg::CNT_W-1:0]   divisor,
    output logic                        done,
    output logic [bee_pkg::TERM_W-1:0]  quotient
);

    logic                         busy_reg;
    logic                         done_reg;
    logic [5:0]                   cnt_reg;
    logic [bee_pkg::TERM_W-1:0]   quo_reg;
    logic [bee_pkg::CNT_W-1:0]    rem_reg;
    logic [bee_pkg::CNT_W-1:0]    dvs_reg;

    logic [bee_pkg::CNT_W:0]      trial;
    logic                         fits;
    logic [bee_pkg::CNT_W:0]      diff;

    assign trial = {rem_reg, quo_reg[bee_pkg::TERM_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'(bee_pkg::TERM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[bee_pkg::CNT_W-1:0] : trial[bee_pkg::CNT_W-1:0];
            quo_reg <= {quo_reg[bee_pkg::TERM_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== design/byte_entropy_estimator_core.sv =====
// ----------------------------------------------------------------------------
// byte_entropy_estimator_core
// Shannon entropy of a byte block, bits per byte in unsigned Q4.16.
// ----------------------------------------------------------------------------
// Bytes arrive on in_ch, one per transfer, with last_byte marking the end of
// a block. Each byte passes through the transfer, then a histogram
// read-modify-write; the first MAX_BYTES bytes of a block are counted.
// After the last byte a sequencer walks all 256 bins: an empty bin is read
// and skipped, a nonzero one also goes through the shared log2 unit, which
// squares its mantissa once per cycle. Then log2 of the byte total, a
// subtract and a restoring divide.
// One result per block leaves on out_ch; in_ch is not ready during the walk.
// If out_ch stalls, the result is held in the output register and the block
// waits with the next result until the previous transfer completes; no bytes
// are taken meanwhile. Reset clears the histogram, the byte total and sets
// the threshold to 7.0. The threshold sits at APB address 0; pready is
// always high and writes complete in the access cycle.
// ----------------------------------------------------------------------------
module byte_entropy_estimator_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    bee_byte_if.sink                      in_ch,
    bee_result_if.source                  out_ch,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bee_pkg::ADDR_W-1:0]    paddr,
    input  logic [bee_pkg::DATA_W-1:0]    pwdata,
    output logic [bee_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    typedef enum logic [10:0] {
        S_IDLE = 11'b00000000001,
        S_UPD  = 11'b00000000010,
        S_RD   = 11'b00000000100,
        S_BIN  = 11'b00000001000,
        S_LOGB = 11'b00000010000,
        S_ACC  = 11'b00000100000,
        S_TOT  = 11'b00001000000,
        S_LOGN = 11'b00010000000,
        S_SUB  = 11'b00100000000,
        S_DIV  = 11'b01000000000,
        S_OUT  = 11'b10000000000
    } state_t;

    state_t                         state_reg, state_next;
    logic [bee_pkg::BIN_W-1:0]      byte_reg, byte_next;
    logic                           last_reg, last_next;
    logic [bee_pkg::BIN_W-1:0]      idx_reg, idx_next;
    logic [bee_pkg::CNT_W-1:0]      total_reg, total_next;
    logic [bee_pkg::TERM_W-1:0]     wsum_reg, wsum_next;
    logic [bee_pkg::CNT_W-1:0]      cval_reg, cval_next;
    logic [bee_pkg::TERM_W-1:0]     prod_reg, prod_next;
    logic [bee_pkg::ENT_W-1:0]      ent_reg, ent_next;
    logic                           empty_reg, empty_next;
    logic                           ovalid_reg, ovalid_next;
    logic [bee_pkg::ENT_W-1:0]      oent_reg, oent_next;
    logic                           oabove_reg, oabove_next;
    logic                           oempty_reg, oempty_next;
    logic [bee_pkg::ENT_W-1:0]      thresh_reg;

    logic [bee_pkg::BIN_W-1:0]      rd_addr;
    logic [bee_pkg::CNT_W-1:0]      hist_count;
    logic                           hist_we;
    logic                           hist_clear;
    logic                           log_start;
    logic [bee_pkg::CNT_W-1:0]      log_x;
    logic                           log_done;
    logic [bee_pkg::LG_W-1:0]       log_res;
    logic                           div_start;
    logic [bee_pkg::TERM_W-1:0]     div_dividend;
    logic                           div_done;
    logic [bee_pkg::TERM_W-1:0]     div_quo;
    logic                           count_ok;
    logic [bee_pkg::CNT_W-1:0]      total_after;
    logic                           apb_wr;

    bee_hist u_hist
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_addr  (rd_addr),
        .rd_count (hist_count),
        .wr_en    (hist_we),
        .wr_addr  (byte_reg),
        .wr_count (hist_count + bee_pkg::CNT_W'(1)),
        .clear    (hist_clear)
    );

    bee_log2 u_log2
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (log_start),
        .x      (log_x),
        .done   (log_done),
        .result (log_res)
    );

    bee_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (total_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign in_ch.ready = (state_reg == S_IDLE);
    assign rd_addr     = (state_reg == S_IDLE) ? in_ch.data_byte : idx_reg;
    assign count_ok    = total_reg < bee_pkg::MAX_BYTES_CNT;
    assign total_after = count_ok ? total_reg + bee_pkg::CNT_W'(1) : total_reg;
    assign hist_we     = (state_reg == S_UPD) && count_ok;
    assign log_start   = ((state_reg == S_BIN) && (hist_count != '0)) || (state_reg == S_TOT);
    assign log_x       = (state_reg == S_TOT) ? total_reg : hist_count;
    assign div_start   = (state_reg == S_SUB);
    assign div_dividend = (prod_reg > wsum_reg) ? prod_reg - wsum_reg : '0;
    assign hist_clear  = (state_reg == S_OUT) && (!ovalid_reg || out_ch.ready);

    always_comb
    begin
        state_next  = state_reg;
        byte_next   = byte_reg;
        last_next   = last_reg;
        idx_next    = idx_reg;
        total_next  = total_reg;
        wsum_next   = wsum_reg;
        cval_next   = cval_reg;
        prod_next   = prod_reg;
        ent_next    = ent_reg;
        empty_next  = empty_reg;
        ovalid_next = ovalid_reg && !out_ch.ready;
        oent_next   = oent_reg;
        oabove_next = oabove_reg;
        oempty_next = oempty_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    byte_next  = in_ch.data_byte;
                    last_next  = in_ch.last_byte;
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                total_next = total_after;
                idx_next   = '0;
                if (!last_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (total_after == '0)
                begin
                    ent_next   = '0;
                    empty_next = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    empty_next = 1'b0;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_BIN;
            end
            S_BIN:
            begin
                if (hist_count != '0)
                begin
                    cval_next  = hist_count;
                    state_next = S_LOGB;
                end
                else if (idx_reg == '1)
                begin
                    state_next = S_TOT;
                end
                else
                begin
                    idx_next   = idx_reg + bee_pkg::BIN_W'(1);
                    state_next = S_RD;
                end
            end
            S_LOGB:
            begin
                if (log_done)
                begin
                    prod_next  = bee_pkg::TERM_W'(cval_reg) * bee_pkg::TERM_W'(log_res);
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                wsum_next = wsum_reg + prod_reg;
                if (idx_reg == '1)
                begin
                    state_next = S_TOT;
                end
                else
                begin
                    idx_next   = idx_reg + bee_pkg::BIN_W'(1);
                    state_next = S_RD;
                end
            end
            S_TOT:
            begin
                state_next = S_LOGN;
            end
            S_LOGN:
            begin
                if (log_done)
                begin
                    prod_next  = bee_pkg::TERM_W'(total_reg) * bee_pkg::TERM_W'(log_res);
                    state_next = S_SUB;
                end
            end
            S_SUB:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    ent_next = (div_quo > bee_pkg::TERM_W'(bee_pkg::ENTROPY_MAX)) ?
                               bee_pkg::ENTROPY_MAX : div_quo[bee_pkg::ENT_W-1:0];
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!ovalid_reg || out_ch.ready)
                begin
                    ovalid_next = 1'b1;
                    oent_next   = ent_reg;
                    oabove_next = !empty_reg && (ent_reg > thresh_reg);
                    oempty_next = empty_reg;
                    total_next  = '0;
                    wsum_next   = '0;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            total_reg  <= '0;
            wsum_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            total_reg  <= total_next;
            wsum_reg   <= wsum_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg   <= byte_next;
        last_reg   <= last_next;
        idx_reg    <= idx_next;
        cval_reg   <= cval_next;
        prod_reg   <= prod_next;
        ent_reg    <= ent_next;
        empty_reg  <= empty_next;
        oent_reg   <= oent_next;
        oabove_reg <= oabove_next;
        oempty_reg <= oempty_next;
    end

    assign out_ch.valid           = ovalid_reg;
    assign out_ch.entropy_value   = oent_reg;
    assign out_ch.above_threshold = oabove_reg;
    assign out_ch.empty_block     = oempty_reg;

    // APB register file
    assign apb_wr = psel && penable && pwrite && (paddr[2] == bee_pkg::REG_THRESH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= bee_pkg::THRESH_RESET;
        end
        else if (apb_wr)
        begin
            thresh_reg <= pwdata[bee_pkg::ENT_W-1:0];
        end
    end

    assign prdata = (paddr[2] == bee_pkg::REG_THRESH) ? bee_pkg::DATA_W'(thresh_reg) : '0;
    assign pready = 1'b1;

endmodule
